### rtl/rvd_pkg.sv
// ----------------------------------------------------------------------------
// rvd_pkg
// Shared widths, codes and structures of the RTP raw video depacketizer.
// ----------------------------------------------------------------------------
package rvd_pkg;

   // Line header storage.
   localparam int MAX_LINES  = 32;
   localparam int LINE_IDX_W = $clog2(MAX_LINES);
   localparam int LINE_CNT_W = $clog2(MAX_LINES + 1);

   // Field and register widths.
   localparam int BYTE_W     = 8;
   localparam int DIM_W      = 13;
   localparam int BPP_W      = 3;
   localparam int PT_W       = 7;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int ADDR_W     = 26;
   localparam int LEN_W      = 16;
   localparam int LNUM_W     = 16;
   localparam int LNM1_W     = 15;
   localparam int OFF_W      = 15;
   localparam int PROD_W     = LNM1_W + DIM_W;
   localparam int FULL_ADDR_W = PROD_W + BPP_W;
   localparam int AREA_W     = 2 * DIM_W;
   localparam int LIMIT_W    = AREA_W + BPP_W;

   // Register reset values and the frame size that follows from them.
   localparam logic [DIM_W-1:0]   RESET_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0]   RESET_HEIGHT = DIM_W'(480);
   localparam logic [BPP_W-1:0]   RESET_BPP    = BPP_W'(2);
   localparam logic [PT_W-1:0]    RESET_PT     = PT_W'(96);
   localparam logic [AREA_W-1:0]  RESET_AREA   = AREA_W'(640 * 480);
   localparam logic [LIMIT_W-1:0] RESET_LIMIT  = LIMIT_W'(640 * 480 * 2);

   // Table refresh after a register write: a settle time, then the sweep over the entries.
   localparam int REFRESH_W = $clog2(MAX_LINES + 4);
   localparam logic [REFRESH_W-1:0] REFRESH_START = REFRESH_W'(MAX_LINES + 3);

   // Byte positions within the datagram.
   localparam int POS_W = 4;
   localparam logic [POS_W-1:0] POS_VERSION = POS_W'(0);
   localparam logic [POS_W-1:0] POS_PTYPE   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_ACCEPT  = POS_W'(3);
   localparam logic [POS_W-1:0] POS_LINES   = POS_W'(14);

   // Byte positions within one 6-byte line header.
   localparam int SUB_W = 3;
   localparam logic [SUB_W-1:0] SUB_FIRST  = SUB_W'(0);
   localparam logic [SUB_W-1:0] SUB_LINE_LO = SUB_W'(3);
   localparam logic [SUB_W-1:0] SUB_LAST   = SUB_W'(5);

   localparam logic [1:0] RTP_VERSION = 2'd2;

   // Result queue.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_BPP          = 2'd2,
      CSR_PAYLOAD_TYPE = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_WRITE      = 1'b0,
      KIND_FRAME_DONE = 1'b1
   } rsp_kind_type;

   typedef struct packed {
      rsp_kind_type        kind;
      logic [ADDR_W-1:0]   addr;
      logic [BYTE_W-1:0]   data;
   } result_type;

   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } push_type;

   typedef struct packed {
      logic [DIM_W-1:0]   width;
      logic [BPP_W-1:0]   bpp;
      logic [PT_W-1:0]    pt;
      logic [LIMIT_W-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic                  en;
      logic [LINE_IDX_W-1:0] idx;
   } refresh_type;

   typedef struct packed {
      logic                  ln_en;
      logic                  entry_en;
      logic [LINE_IDX_W-1:0] idx;
      logic [LNM1_W-1:0]     lnm1;
      logic [LEN_W-1:0]      len;
      logic [OFF_W-1:0]      off;
      logic                  stop;
      logic                  skip;
   } tbl_wr_type;

   typedef struct packed {
      logic [LINE_CNT_W-1:0] start;
      logic [LINE_CNT_W-1:0] total;
   } tbl_query_type;

   typedef struct packed {
      logic                  found;
      logic                  stop;
      logic [LINE_IDX_W-1:0] idx;
      logic [LEN_W-1:0]      len;
      logic [PROD_W-1:0]     prod;
      logic [OFF_W-1:0]      off;
   } tbl_hit_type;

endpackage

### rtl/rvd_cfg_regs.sv
// ----------------------------------------------------------------------------
// rvd_cfg_regs
// Configuration registers, frame size product and the refresh sequencer
// that runs after every register write.
// ----------------------------------------------------------------------------
module rvd_cfg_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [rvd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rvd_pkg::CSR_DATA_W-1:0] csr_write_data,
   output rvd_pkg::cfg_type               cfg,
   output logic                           busy,
   output rvd_pkg::refresh_type           refresh
);
   import rvd_pkg::*;

   logic [DIM_W-1:0]     width_ff;
   logic [DIM_W-1:0]     height_ff;
   logic [BPP_W-1:0]     bpp_ff;
   logic [PT_W-1:0]      pt_ff;
   logic [AREA_W-1:0]    area_ff;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [REFRESH_W-1:0] refresh_cnt_ff;
   logic [REFRESH_W-1:0] refresh_cnt_in;

   always_comb begin
      refresh_cnt_in = refresh_cnt_ff;
      if (csr_write_enable) begin
         refresh_cnt_in = REFRESH_START;
      end else if (refresh_cnt_ff != '0) begin
         refresh_cnt_in = refresh_cnt_ff - REFRESH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= RESET_WIDTH;
         height_ff      <= RESET_HEIGHT;
         bpp_ff         <= RESET_BPP;
         pt_ff          <= RESET_PT;
         area_ff        <= RESET_AREA;
         limit_ff       <= RESET_LIMIT;
         refresh_cnt_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_FRAME_WIDTH:  width_ff  <= csr_write_data[DIM_W-1:0];
               CSR_FRAME_HEIGHT: height_ff <= csr_write_data[DIM_W-1:0];
               CSR_BPP:          bpp_ff    <= csr_write_data[BPP_W-1:0];
               CSR_PAYLOAD_TYPE: pt_ff     <= csr_write_data[PT_W-1:0];
               default: ;
            endcase
         end
         // Two registered multiplies; the refresh window covers their latency.
         area_ff        <= AREA_W'(width_ff) * AREA_W'(height_ff);
         limit_ff       <= LIMIT_W'(area_ff) * LIMIT_W'(bpp_ff);
         refresh_cnt_ff <= refresh_cnt_in;
      end
   end

   assign cfg.width = width_ff;
   assign cfg.bpp   = bpp_ff;
   assign cfg.pt    = pt_ff;
   assign cfg.limit = limit_ff;

   assign busy = (refresh_cnt_ff != '0);

   // Entries are refreshed from the top down while the count runs through
   // MAX_LINES .. 1.
   assign refresh.en  = (refresh_cnt_ff != '0) &&
                        (refresh_cnt_ff <= REFRESH_W'(MAX_LINES));
   assign refresh.idx = LINE_IDX_W'(refresh_cnt_ff - REFRESH_W'(1));

`ifndef SYNTH
   a_write_starts_refresh: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> busy)
      else $error("register write did not hold off the input");
`endif

endmodule

### rtl/rvd_line_table.sv
// ----------------------------------------------------------------------------
// rvd_line_table
// Storage for the line headers of one packet, with the search for the next
// line that has bytes to receive and the row product refresh.
// ----------------------------------------------------------------------------
module rvd_line_table (
   input  logic                              clock,
   input  rvd_pkg::tbl_wr_type               wr,
   input  rvd_pkg::refresh_type              refresh,
   input  logic [rvd_pkg::DIM_W-1:0]         width,
   input  rvd_pkg::tbl_query_type            query,
   output rvd_pkg::tbl_hit_type              hit
);
   import rvd_pkg::*;

   logic [LEN_W-1:0]     len_mem  [MAX_LINES];
   logic [LNM1_W-1:0]    lnm1_mem [MAX_LINES];
   logic [PROD_W-1:0]    prod_mem [MAX_LINES];
   logic [OFF_W-1:0]     off_mem  [MAX_LINES];
   logic [MAX_LINES-1:0] stop_vec_ff;
   logic [MAX_LINES-1:0] skip_vec_ff;

   logic [LINE_IDX_W-1:0] prod_idx;
   logic [LNM1_W-1:0]     prod_lnm1;
   logic [PROD_W-1:0]     prod_value;
   logic [MAX_LINES-1:0]  stop_eff;
   logic [MAX_LINES-1:0]  skip_eff;
   logic [MAX_LINES-1:0]  cand;
   logic [MAX_LINES-1:0]  lowest;
   logic [LINE_IDX_W-1:0] hit_idx;
   logic                  bypass;

   // One multiplier serves the line header write and the refresh sweep.
   assign prod_idx   = wr.ln_en ? wr.idx : refresh.idx;
   assign prod_lnm1  = wr.ln_en ? wr.lnm1 : lnm1_mem[refresh.idx];
   assign prod_value = PROD_W'(prod_lnm1) * PROD_W'(width);

   always_ff @(posedge clock) begin
      if (wr.ln_en) begin
         lnm1_mem[wr.idx] <= wr.lnm1;
      end
      if (wr.ln_en || refresh.en) begin
         prod_mem[prod_idx] <= prod_value;
      end
      if (wr.entry_en) begin
         len_mem[wr.idx]     <= wr.len;
         off_mem[wr.idx]     <= wr.off;
         stop_vec_ff[wr.idx] <= wr.stop;
         skip_vec_ff[wr.idx] <= wr.skip;
      end
   end

   // Candidates: entries in range that are not zero-length lines.
   always_comb begin
      stop_eff = stop_vec_ff;
      skip_eff = skip_vec_ff;
      if (wr.entry_en) begin
         stop_eff[wr.idx] = wr.stop;
         skip_eff[wr.idx] = wr.skip;
      end
      for (int i = 0; i < MAX_LINES; i++) begin
         cand[i] = (LINE_CNT_W'(i) >= query.start) && (LINE_CNT_W'(i) < query.total) &&
                   !skip_eff[i];
      end
      lowest  = cand & (~cand + MAX_LINES'(1));
      hit_idx = '0;
      for (int i = 0; i < MAX_LINES; i++) begin
         if (lowest[i]) begin
            hit_idx = hit_idx | LINE_IDX_W'(i);
         end
      end
   end

   assign bypass = wr.entry_en && (wr.idx == hit_idx);

   assign hit.found = |cand;
   assign hit.stop  = stop_eff[hit_idx];
   assign hit.idx   = hit_idx;
   assign hit.len   = bypass ? wr.len : len_mem[hit_idx];
   assign hit.off   = bypass ? wr.off : off_mem[hit_idx];
   assign hit.prod  = prod_mem[hit_idx];

endmodule

### rtl/rvd_parser.sv
// ----------------------------------------------------------------------------
// rvd_parser
// Per-byte datagram parser: RTP header check, line header collection and
// frame-buffer address generation.
// ----------------------------------------------------------------------------
module rvd_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_fire,
   input  logic [rvd_pkg::BYTE_W-1:0]  packet_byte,
   input  logic                        datagram_end,
   input  rvd_pkg::cfg_type            cfg,
   input  rvd_pkg::tbl_hit_type        hit,
   output rvd_pkg::tbl_wr_type         tbl_wr,
   output rvd_pkg::tbl_query_type      query,
   output rvd_pkg::push_type           push
);
   import rvd_pkg::*;

   // Control state.
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  accepted_ff, accepted_in;
   logic                  marker_ff, marker_in;
   logic                  more_ff, more_in;
   logic                  drop_ff, drop_in;
   logic [SUB_W-1:0]      sub_ff, sub_in;
   logic [LINE_CNT_W-1:0] total_ff, total_in;
   logic                  active_ff, active_in;

   // Data state.
   logic                   ver_ok_ff, ver_ok_in;
   logic [PT_W-1:0]        pt_ff, pt_in;
   logic [5*BYTE_W-1:0]    asm_ff, asm_in;
   logic [LINE_IDX_W-1:0]  cursor_ff, cursor_in;
   logic [LEN_W-1:0]       bytes_left_ff, bytes_left_in;
   logic [FULL_ADDR_W-1:0] next_addr_ff, next_addr_in;

   logic                   lines_phase;
   logic [LNUM_W-1:0]      ln_lo_word;
   logic [LNUM_W-1:0]      entry_ln;
   logic [LEN_W-1:0]       entry_len;
   logic [LNUM_W-1:0]      entry_off;
   logic [PROD_W-1:0]      row_sum;
   logic [FULL_ADDR_W-1:0] load_addr;
   logic                   do_load;
   result_type             write_res;
   result_type             done_res;

   assign lines_phase = accepted_ff && !drop_ff && (pos_ff == POS_LINES);
   assign ln_lo_word  = {asm_ff[BYTE_W-1:0], packet_byte};
   assign entry_len   = asm_ff[5*BYTE_W-1:3*BYTE_W];
   assign entry_ln    = asm_ff[3*BYTE_W-1:BYTE_W];
   assign entry_off   = {asm_ff[BYTE_W-1:0], packet_byte};

   // Start address of the line that the search picked.
   assign row_sum   = hit.prod + PROD_W'(hit.off);
   assign load_addr = FULL_ADDR_W'(row_sum) * FULL_ADDR_W'(cfg.bpp);

   // At the end of the headers the search covers every entry, the one being
   // written included; during payload it starts after the current line.
   assign query.start = more_ff ? '0 : LINE_CNT_W'(cursor_ff) + LINE_CNT_W'(1);
   assign query.total = more_ff ? total_ff + LINE_CNT_W'(1) : total_ff;

   assign write_res.kind = KIND_WRITE;
   assign write_res.addr = next_addr_ff[ADDR_W-1:0];
   assign write_res.data = packet_byte;
   assign done_res.kind  = KIND_FRAME_DONE;
   assign done_res.addr  = '0;
   assign done_res.data  = '0;

   always_comb begin
      pos_in        = pos_ff;
      accepted_in   = accepted_ff;
      marker_in     = marker_ff;
      more_in       = more_ff;
      drop_in       = drop_ff;
      sub_in        = sub_ff;
      total_in      = total_ff;
      active_in     = active_ff;
      ver_ok_in     = ver_ok_ff;
      pt_in         = pt_ff;
      asm_in        = asm_ff;
      cursor_in     = cursor_ff;
      bytes_left_in = bytes_left_ff;
      next_addr_in  = next_addr_ff;
      do_load       = 1'b0;

      tbl_wr          = '0;
      tbl_wr.idx      = total_ff[LINE_IDX_W-1:0];
      tbl_wr.lnm1     = LNM1_W'(ln_lo_word - LNUM_W'(1));
      tbl_wr.len      = entry_len;
      tbl_wr.off      = entry_off[OFF_W-1:0];
      tbl_wr.stop     = (entry_ln == '0);
      tbl_wr.skip     = (entry_ln != '0) && (entry_len == '0);

      push        = '0;
      push.first  = write_res;
      push.second = done_res;

      if (in_fire) begin
         if (pos_ff < POS_ACCEPT + POS_W'(1)) begin
            if (pos_ff == POS_VERSION) begin
               ver_ok_in = (packet_byte[7:6] == RTP_VERSION);
            end
            if (pos_ff == POS_PTYPE) begin
               marker_in = packet_byte[7];
               pt_in     = packet_byte[PT_W-1:0];
            end
            if (pos_ff == POS_ACCEPT) begin
               accepted_in = ver_ok_ff && (pt_ff == cfg.pt);
            end
         end else if (lines_phase) begin
            if (more_ff) begin
               if (total_ff >= LINE_CNT_W'(MAX_LINES)) begin
                  if (sub_ff == SUB_FIRST) begin
                     drop_in = 1'b1;
                  end
               end else begin
                  asm_in = {asm_ff[4*BYTE_W-1:0], packet_byte};
                  sub_in = (sub_ff == SUB_LAST) ? SUB_FIRST : sub_ff + SUB_W'(1);
                  if (sub_ff == SUB_LINE_LO) begin
                     tbl_wr.ln_en = 1'b1;
                  end
                  if (sub_ff == SUB_LAST) begin
                     tbl_wr.entry_en = 1'b1;
                     total_in        = total_ff + LINE_CNT_W'(1);
                     // Continuation bit clear: this was the last line header.
                     if (!entry_off[LNUM_W-1]) begin
                        more_in = 1'b0;
                        do_load = 1'b1;
                     end
                  end
               end
            end else if (active_ff) begin
               if (next_addr_ff < FULL_ADDR_W'(cfg.limit)) begin
                  push.count = 2'd1;
               end
               next_addr_in  = next_addr_ff + FULL_ADDR_W'(1);
               bytes_left_in = bytes_left_ff - LEN_W'(1);
               if (bytes_left_ff == LEN_W'(1)) begin
                  do_load = 1'b1;
               end
            end
         end

         if (do_load) begin
            // A line number of zero ends the packet's writes.
            active_in = hit.found && !hit.stop;
            if (hit.found && !hit.stop) begin
               cursor_in     = hit.idx;
               bytes_left_in = hit.len;
               next_addr_in  = load_addr;
            end
         end

         if (pos_ff != POS_LINES) begin
            pos_in = pos_ff + POS_W'(1);
         end

         if (datagram_end) begin
            if (accepted_in && marker_in && !drop_in) begin
               if (push.count == 2'd1) begin
                  push.count = 2'd2;
               end else begin
                  push.count = 2'd1;
                  push.first = done_res;
               end
            end
            pos_in      = POS_VERSION;
            accepted_in = 1'b0;
            marker_in   = 1'b0;
            more_in     = 1'b1;
            drop_in     = 1'b0;
            sub_in      = SUB_FIRST;
            total_in    = '0;
            active_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_VERSION;
         accepted_ff <= 1'b0;
         marker_ff   <= 1'b0;
         more_ff     <= 1'b1;
         drop_ff     <= 1'b0;
         sub_ff      <= SUB_FIRST;
         total_ff    <= '0;
         active_ff   <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         accepted_ff <= accepted_in;
         marker_ff   <= marker_in;
         more_ff     <= more_in;
         drop_ff     <= drop_in;
         sub_ff      <= sub_in;
         total_ff    <= total_in;
         active_ff   <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      ver_ok_ff     <= ver_ok_in;
      pt_ff         <= pt_in;
      asm_ff        <= asm_in;
      cursor_ff     <= cursor_in;
      bytes_left_ff <= bytes_left_in;
      next_addr_ff  <= next_addr_in;
   end

`ifndef SYNTH
   a_active_line_valid: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> ((LINE_CNT_W'(cursor_ff) < total_ff) && (bytes_left_ff != '0)))
      else $error("active line outside the stored line headers");

   a_end_clears_packet: assert property (@(posedge clock) disable iff (reset)
      (in_fire && datagram_end) |=> ((pos_ff == POS_VERSION) && more_ff && !active_ff))
      else $error("packet state not cleared after the last byte");
`endif

endmodule

### rtl/rvd_result_fifo.sv
// ----------------------------------------------------------------------------
// rvd_result_fifo
// Small result queue that takes up to two results per cycle and hands out
// one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module rvd_result_fifo (
   input  logic                clock,
   input  logic                reset,
   input  rvd_pkg::push_type   push,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output rvd_pkg::result_type out_data
);
   import rvd_pkg::*;

   result_type            slot_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic                  pop;
   logic [FIFO_PTR_W-1:0] wr_ptr_next;

   assign pop         = out_valid && out_ready;
   assign wr_ptr_next = wr_ptr_ff + FIFO_PTR_W'(1);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_mem[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(push.count);
         rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(pop);
         count_ff  <= count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
      end
   end

   // Room for the largest burst one byte can cause.
   assign room      = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_mem[rd_ptr_ff];

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
      else $error("result pushed without room in the queue");
`endif

endmodule

### rtl/rtp_raw_video_depacketizer_top.sv
// ----------------------------------------------------------------------------
// rtp_raw_video_depacketizer_top
// Uncompressed RTP video depacketizer: turns datagram bytes into
// frame-buffer byte writes and frame-complete events.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one datagram byte per beat, with req_datagram_end
// set on the final byte. The rsp channel returns results: rsp_kind low is a
// frame-buffer write of rsp_write_data at rsp_write_address, rsp_kind high
// reports that a marker packet has ended (address and data are zero).
// A byte is parsed in the cycle it is accepted; its results are registered
// into the result queue and reach rsp in order. One byte is taken every
// clock while no refresh runs and the receiver keeps up. A byte can cause two
// results (its write and the frame-complete report), buffered in a
// four-entry result queue; req_ready also drops while that queue could not
// take two more results, so a stalled receiver holds the input back once
// three or more results wait in the queue.
// Each register write on the csr port holds req_ready low while the frame
// size product and the stored row products of the line headers are
// recomputed.
// Reset restores the register defaults (640 x 480, 2 bytes per pixel,
// payload type 96), empties the result queue and starts a new datagram.
// ----------------------------------------------------------------------------
module rtp_raw_video_depacketizer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rvd_pkg::BYTE_W-1:0]     req_packet_byte,
   input  logic                           req_datagram_end,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_kind,
   output logic [rvd_pkg::ADDR_W-1:0]     rsp_write_address,
   output logic [rvd_pkg::BYTE_W-1:0]     rsp_write_data,
   input  logic                           csr_write_enable,
   input  logic [rvd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rvd_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import rvd_pkg::*;

   cfg_type       cfg;
   refresh_type   refresh;
   logic          busy;
   tbl_wr_type    tbl_wr;
   tbl_query_type query;
   tbl_hit_type   hit;
   push_type      push;
   logic          room;
   logic          in_fire;
   result_type    head;

   // A byte is taken only when no refresh is running and the queue can
   // hold both results that the byte might produce.
   assign req_ready = !busy && room;
   assign in_fire   = req_valid && req_ready;

   rvd_cfg_regs u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .busy             (busy),
      .refresh          (refresh)
   );

   // Line headers of the current packet. The row product of each line is
   // stored when its line number arrives, so a line can start on the byte
   // right after the last header.
   rvd_line_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .refresh (refresh),
      .width   (cfg.width),
      .query   (query),
      .hit     (hit)
   );

   rvd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .in_fire      (in_fire),
      .packet_byte  (req_packet_byte),
      .datagram_end (req_datagram_end),
      .cfg          (cfg),
      .hit          (hit),
      .tbl_wr       (tbl_wr),
      .query        (query),
      .push         (push)
   );

   rvd_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head)
   );

   assign rsp_kind          = head.kind;
   assign rsp_write_address = head.addr;
   assign rsp_write_data    = head.data;

endmodule
